// ===== hw/rtl/rgbci_pkg.sv =====
package rgbci_pkg;

  // position format: t = t_fraction / 2^FRAC_BITS
  localparam int FRAC_BITS = 16;

  localparam int T_W     = 16;
  localparam int C_W     = 8;
  localparam int LANES   = 4;
  localparam int PIX_W   = LANES * C_W;
  localparam int C_MAX   = (1 << C_W) - 1;

  // pipeline depth, input register to output register
  localparam int NSTG    = 6;

  // doubled cubic coefficients per lane
  localparam int KA_W    = C_W + 3;
  localparam int KB_W    = C_W + 4;
  localparam int KC_W    = C_W + 1;
  localparam int TS_W    = T_W + 1;

  // u = A*t + B*S
  localparam int UA_W    = KA_W + T_W;
  localparam int UB_W    = KB_W + FRAC_BITS;
  localparam int U_W     = ((UA_W > UB_W) ? UA_W : UB_W) + 1;

  // v = u*t + C*S^2
  localparam int VA_W    = U_W + T_W;
  localparam int VB_W    = KC_W + 2 * FRAC_BITS;
  localparam int V_W     = ((VA_W > VB_W) ? VA_W : VB_W) + 1;

  // v*t is built from two partial products
  localparam int VL_W    = V_W / 2;
  localparam int VH_W    = V_W - VL_W;
  localparam int PL_W    = VL_W + T_W;
  localparam int PH_W    = VH_W + TS_W;

  // w = v*t + S^3, offset = w >>> (3F+1)
  localparam int HALF_SH = 3 * FRAC_BITS;
  localparam int RND_SH  = HALF_SH + 1;
  localparam int WP_W    = V_W + T_W;
  localparam int W_W     = ((WP_W > (HALF_SH + 2)) ? WP_W : (HALF_SH + 2)) + 1;
  localparam int R_W     = W_W - RND_SH;
  localparam int SUM_W   = ((R_W > C_W) ? R_W : C_W) + 2;

  typedef struct packed {
    logic [NSTG-1:0] load;
  } rgbci_stage_ctl_t;

endpackage

// ===== hw/rtl/rgbci_in_if.sv =====
interface rgbci_in_if import rgbci_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [T_W-1:0]   t_fraction;
  logic [PIX_W-1:0] pixel_p0;
  logic [PIX_W-1:0] pixel_p1;
  logic [PIX_W-1:0] pixel_p2;
  logic [PIX_W-1:0] pixel_p3;

  modport source (
    output valid, t_fraction, pixel_p0, pixel_p1, pixel_p2, pixel_p3,
    input  ready
  );

  modport sink (
    input  valid, t_fraction, pixel_p0, pixel_p1, pixel_p2, pixel_p3,
    output ready
  );
endinterface

// ===== hw/rtl/rgbci_out_if.sv =====
interface rgbci_out_if import rgbci_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;

  modport source (
    output valid, pixel_out,
    input  ready
  );

  modport sink (
    input  valid, pixel_out,
    output ready
  );
endinterface

// ===== hw/rtl/rgbci_lane.sv =====
module rgbci_lane import rgbci_pkg::*; (
  input  logic             clk,
  input  rgbci_stage_ctl_t ctl,
  input  logic [T_W-1:0]   t,
  input  logic [C_W-1:0]   c0,
  input  logic [C_W-1:0]   c1,
  input  logic [C_W-1:0]   c2,
  input  logic [C_W-1:0]   c3,
  output logic [C_W-1:0]   y
);

  localparam logic signed [W_W-1:0] HALF = W_W'(1) <<< HALF_SH;

  // stage 1: coefficients
  logic signed [KB_W-1:0] e0, e1, e2, e3, d12, ka_full, kb_nxt;
  logic signed [KA_W-1:0] ka_r, ka_nxt;
  logic signed [KB_W-1:0] kb_r;
  logic signed [KC_W-1:0] kc1_r, kc_nxt;
  logic [C_W-1:0]         c1_1_r;
  logic [T_W-1:0]         t1_r;

  // stage 2
  logic signed [U_W-1:0]  u_r, u_nxt;
  logic signed [KC_W-1:0] kc2_r;
  logic [C_W-1:0]         c1_2_r;
  logic [T_W-1:0]         t2_r;

  // stage 3
  logic signed [V_W-1:0]  v_r, v_nxt;
  logic [C_W-1:0]         c1_3_r;
  logic [T_W-1:0]         t3_r;

  // stage 4
  logic [PL_W-1:0]        pl_r, pl_nxt;
  logic signed [PH_W-1:0] ph_r, ph_nxt;
  logic [C_W-1:0]         c1_4_r;

  // stage 5
  logic signed [W_W-1:0]  w_r, w_nxt;
  logic [C_W-1:0]         c1_5_r;

  // stage 6
  logic signed [R_W-1:0]   ofs;
  logic signed [SUM_W-1:0] sum;
  logic [C_W-1:0]          y_r, y_nxt;

  always_comb begin
    e0      = $signed(KB_W'(c0));
    e1      = $signed(KB_W'(c1));
    e2      = $signed(KB_W'(c2));
    e3      = $signed(KB_W'(c3));
    d12     = e1 - e2;
    ka_full = e3 - e0 + d12 + (d12 <<< 1);
    ka_nxt  = KA_W'(ka_full);
    kb_nxt  = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    kc_nxt  = KC_W'(e2 - e0);
  end

  always_comb begin
    u_nxt = U_W'(ka_r) * $signed(U_W'(t1_r)) + (U_W'(kb_r) <<< FRAC_BITS);
  end

  always_comb begin
    v_nxt = V_W'(u_r) * $signed(V_W'(t2_r)) + (V_W'(kc2_r) <<< (2 * FRAC_BITS));
  end

  // low half unsigned, high half signed
  always_comb begin
    pl_nxt = PL_W'(v_r[VL_W-1:0]) * PL_W'(t3_r);
    ph_nxt = PH_W'($signed(v_r[V_W-1:VL_W])) * $signed(PH_W'(t3_r));
  end

  always_comb begin
    w_nxt = (W_W'(ph_r) <<< VL_W) + $signed(W_W'(pl_r)) + HALF;
  end

  // floor of the offset, add d, clamp to a byte
  always_comb begin
    ofs = $signed(w_r[W_W-1:RND_SH]);
    sum = SUM_W'(ofs) + $signed(SUM_W'(c1_5_r));
    if (sum[SUM_W-1]) begin
      y_nxt = '0;
    end else if (sum > $signed(SUM_W'(C_MAX))) begin
      y_nxt = C_W'(C_MAX);
    end else begin
      y_nxt = sum[C_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      ka_r   <= ka_nxt;
      kb_r   <= kb_nxt;
      kc1_r  <= kc_nxt;
      c1_1_r <= c1;
      t1_r   <= t;
    end
    if (ctl.load[1]) begin
      u_r    <= u_nxt;
      kc2_r  <= kc1_r;
      c1_2_r <= c1_1_r;
      t2_r   <= t1_r;
    end
    if (ctl.load[2]) begin
      v_r    <= v_nxt;
      c1_3_r <= c1_2_r;
      t3_r   <= t2_r;
    end
    if (ctl.load[3]) begin
      pl_r   <= pl_nxt;
      ph_r   <= ph_nxt;
      c1_4_r <= c1_3_r;
    end
    if (ctl.load[4]) begin
      w_r    <= w_nxt;
      c1_5_r <= c1_4_r;
    end
    if (ctl.load[5]) begin
      y_r    <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

// ===== hw/rtl/rgba_cubic_interpolator_core.sv =====
// Catmull-Rom cubic interpolation of packed RGBA pixels.
// in_ch carries one word per item: t_fraction and the four neighbouring
// pixels p0..p3; out_ch returns one packed pixel per item, each byte
// rounded half up and clamped to 0..255. Both channels use valid/ready,
// a word moving on an edge where both are high.
// Each accepted word passes through the six register stages in order
// (coefficients, two multiply-adds, split partial products, rounding sum,
// clamp) before out_ch.valid rises. Throughput: one word per cycle while
// the receiver does not stall, all four byte lanes in parallel.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so a stalled receiver holds the output word while
// bubbles further up still close; in_ch.ready falls only once the whole
// pipeline is full. Words are never dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline; there is no other
// state and no configuration.
module rgba_cubic_interpolator_core import rgbci_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  rgbci_in_if.sink    in_ch,
  rgbci_out_if.source out_ch
);

  logic [NSTG-1:0]  vld_r, vld_nxt;
  rgbci_stage_ctl_t ctl;
  logic [C_W-1:0]   lane_y [LANES];

  always_comb begin
    ctl.load[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ctl.load[k] = !vld_r[k] || ctl.load[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (ctl.load[0]) begin
      vld_nxt[0] = in_ch.valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (ctl.load[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    rgbci_lane u_lane (
      .clk (clk),
      .ctl (ctl),
      .t   (in_ch.t_fraction),
      .c0  (in_ch.pixel_p0[g*C_W +: C_W]),
      .c1  (in_ch.pixel_p1[g*C_W +: C_W]),
      .c2  (in_ch.pixel_p2[g*C_W +: C_W]),
      .c3  (in_ch.pixel_p3[g*C_W +: C_W]),
      .y   (lane_y[g])
    );
    assign out_ch.pixel_out[g*C_W +: C_W] = lane_y[g];
  end

  assign in_ch.ready  = ctl.load[0];
  assign out_ch.valid = vld_r[NSTG-1];

`ifndef SYNTHESIS
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while receiver ready");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted word not captured");

  a_reach_out: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG-2] && ctl.load[NSTG-1]) |=> out_ch.valid)
    else $error("word lost before output register");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule
